### src/acge_pkg.sv
`default_nettype none
package acge_pkg;

    localparam int CHANNELS    = 8;
    localparam int CH_BITS     = 3;
    localparam int WINDOW      = 32;
    localparam int WIN_BITS    = 5;
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 17;
    localparam int SUM_BITS    = 2 * SAMPLE_BITS + WIN_BITS;

    localparam logic [16:0] GAIN_UNITY = 17'd65536;

    typedef enum logic [2:0] {
        PH_OPEN     = 3'd0,
        PH_ATTACK   = 3'd1,
        PH_COMPRESS = 3'd2,
        PH_HOLD     = 3'd3,
        PH_RELEASE  = 3'd4
    } phase_code_t;

    typedef enum logic [2:0] {
        REG_ENABLE       = 3'd0,
        REG_DETECT_MODE  = 3'd1,
        REG_THRESHOLD    = 3'd2,
        REG_GAIN_FLOOR   = 3'd3,
        REG_ATTACK_STEP  = 3'd4,
        REG_RELEASE_STEP = 3'd5,
        REG_HOLD_SAMPLES = 3'd6,
        REG_MAKEUP_GAIN  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [2:0]         channel;
        logic signed [23:0] sample_in;
    } in_item_t;

    typedef struct packed {
        logic signed [23:0] sample_out;
        logic [16:0]        gain_now;
        logic [2:0]         phase_now;
    } out_item_t;

    // Work handed from the front part to the back part.
    typedef struct packed {
        logic [2:0]         channel;
        logic signed [23:0] sample;
        logic               active;
        logic               fired;
    } job_t;

    typedef struct packed {
        logic        enable;
        logic        detect_mode;
        logic [22:0] threshold;
        logic [16:0] gain_floor;
        logic [15:0] attack_step;
        logic [15:0] release_step;
        logic [15:0] hold_samples;
        logic [15:0] makeup_gain;
    } cfg_t;

endpackage
`default_nettype wire

### src/acge_front.sv
`default_nettype none
// Level detector: keeps the per-channel windows in one memory and sums
// the squares one entry per cycle.
module acge_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire acge_pkg::cfg_t    cfg,
    input  wire logic              push,
    output logic                   full,
    input  wire acge_pkg::in_item_t in_item,
    output logic                   job_valid,
    input  wire logic              job_ready,
    output acge_pkg::job_t         job
);

    typedef enum logic [5:0] {
        F_CLEAR = 6'b000001,
        F_IDLE  = 6'b000010,
        F_READ  = 6'b000100,
        F_SUM   = 6'b001000,
        F_CMP   = 6'b010000,
        F_SEND  = 6'b100000
    } fstate_t;

    localparam int ADDR_BITS = acge_pkg::CH_BITS + acge_pkg::WIN_BITS;

    fstate_t state_reg, state_next;
    logic signed [23:0] win_mem [acge_pkg::CHANNELS * acge_pkg::WINDOW];
    logic [acge_pkg::WIN_BITS-1:0] head_reg [acge_pkg::CHANNELS];
    logic [ADDR_BITS-1:0] clr_reg;
    logic [acge_pkg::WIN_BITS:0] idx_reg;
    logic signed [23:0] rd_reg;
    logic rd_valid_reg;
    logic [acge_pkg::SUM_BITS-1:0] sum_reg;
    logic [acge_pkg::SUM_BITS-1:0] lim_reg;
    logic [45:0] tsq_reg;
    logic [23:0] mag_rd;
    logic [47:0] sq_rd;
    logic [23:0] mag_in;
    acge_pkg::job_t job_reg;
    logic [acge_pkg::WIN_BITS-1:0] head_cur;
    logic [ADDR_BITS-1:0] rd_addr;

    assign full      = (state_reg != F_IDLE);
    assign job_valid = (state_reg == F_SEND);
    assign job       = job_reg;
    assign head_cur  = head_reg[job_reg.channel];
    assign rd_addr   = {job_reg.channel, head_cur + idx_reg[acge_pkg::WIN_BITS-1:0]};
    assign mag_rd    = rd_reg[23] ? 24'(-rd_reg) : 24'(rd_reg);
    assign sq_rd     = mag_rd * mag_rd;
    assign mag_in    = in_item.sample_in[23] ? 24'(-in_item.sample_in)
                                              : 24'(in_item.sample_in);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_CLEAR: if (clr_reg == '1) state_next = F_IDLE;
            F_IDLE:
                if (push)
                    state_next = (cfg.enable && cfg.detect_mode) ? F_READ : F_SEND;
            F_READ:  if (idx_reg == 6'(acge_pkg::WINDOW)) state_next = F_SUM;
            F_SUM:   state_next = F_CMP;
            F_CMP:   state_next = F_SEND;
            F_SEND:  if (job_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_CLEAR;
            clr_reg      <= '0;
            rd_valid_reg <= 1'b0;
            for (int i = 0; i < acge_pkg::CHANNELS; i++)
                head_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            rd_valid_reg <= (state_reg == F_READ) && (idx_reg != 6'(acge_pkg::WINDOW));
            if (state_reg == F_IDLE && push && cfg.enable && cfg.detect_mode)
                head_reg[in_item.channel] <= head_reg[in_item.channel] - 1'b1;
        end
    end

    // Window memory: one write, one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == F_CLEAR)
            win_mem[clr_reg] <= '0;
        else if (state_reg == F_IDLE && push && cfg.enable && cfg.detect_mode)
            win_mem[{in_item.channel, head_reg[in_item.channel] - 1'b1}]
                <= in_item.sample_in;
        rd_reg <= win_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            F_IDLE:
            begin
                job_reg.channel <= in_item.channel;
                job_reg.sample  <= in_item.sample_in;
                job_reg.active  <= cfg.enable;
                job_reg.fired   <= (mag_in >= {1'b0, cfg.threshold});
                idx_reg         <= '0;
                sum_reg         <= '0;
                tsq_reg         <= cfg.threshold * cfg.threshold;
            end
            F_READ:
            begin
                if (idx_reg != 6'(acge_pkg::WINDOW))
                    idx_reg <= idx_reg + 1'b1;
                if (rd_valid_reg)
                    sum_reg <= sum_reg + acge_pkg::SUM_BITS'(sq_rd);
                lim_reg <= acge_pkg::SUM_BITS'({tsq_reg, 5'd0});
            end
            F_SUM:
                if (rd_valid_reg)
                    sum_reg <= sum_reg + acge_pkg::SUM_BITS'(sq_rd);
            F_CMP:
                job_reg.fired <= (sum_reg >= lim_reg);
            default: ;
        endcase
    end

endmodule
`default_nettype wire

### src/acge_queue.sv
`default_nettype none
// Two-entry queue between the detector and the envelope.
module acge_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire acge_pkg::job_t wr_data,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output acge_pkg::job_t      rd_data
);

    acge_pkg::job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge clk)
        if (do_wr) mem_reg[wp_reg] <= wr_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (do_wr) wp_reg <= ~wp_reg;
            if (do_rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule
`default_nettype wire

### src/acge_back.sv
`default_nettype none
// Envelope update and output scaling, two multiplier stages.
module acge_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire acge_pkg::cfg_t cfg,
    input  wire logic           job_valid,
    output logic                job_ready,
    input  wire acge_pkg::job_t job,
    output logic                empty,
    input  wire logic           pop,
    output acge_pkg::out_item_t out_item
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL1 = 4'b0010,
        B_MUL2 = 4'b0100,
        B_DONE = 4'b1000
    } bstate_t;

    bstate_t state_reg;
    acge_pkg::phase_code_t phase_reg [acge_pkg::CHANNELS];
    logic [16:0] gain_reg [acge_pkg::CHANNELS];
    logic [15:0] hold_reg [acge_pkg::CHANNELS];

    acge_pkg::phase_code_t ph0, ph1, ph2;
    logic [16:0] g0, g1;
    logic [15:0] h0, h1, h2;
    logic [17:0] g_add;

    logic [23:0] mag_reg;
    logic        neg_reg, act_reg;
    logic [16:0] gain_use_reg;
    logic [40:0] p1_reg;
    logic [56:0] p2_reg;
    logic signed [23:0] pass_reg;
    logic [2:0]  ph_out_reg;
    logic [27:0] q;
    logic signed [23:0] sat;
    acge_pkg::out_item_t out_reg;
    logic        out_full_reg;

    assign g_add = {1'b0, g0} + {2'b0, cfg.release_step};

    always_comb
    begin
        ph0 = phase_reg[job.channel];
        g0  = gain_reg[job.channel];
        h0  = hold_reg[job.channel];
        ph1 = ph0; g1 = g0; h1 = h0;
        unique case (ph0)
            acge_pkg::PH_ATTACK:
            begin
                g1 = (g0 > {1'b0, cfg.attack_step}) ? g0 - {1'b0, cfg.attack_step} : '0;
                if (g1 <= cfg.gain_floor) ph1 = acge_pkg::PH_COMPRESS;
            end
            acge_pkg::PH_HOLD:
            begin
                if (h0 != 16'hFFFF) h1 = h0 + 1'b1;
                if (h1 >= cfg.hold_samples) ph1 = acge_pkg::PH_RELEASE;
            end
            acge_pkg::PH_RELEASE:
            begin
                if (g_add >= {1'b0, acge_pkg::GAIN_UNITY})
                begin
                    g1 = acge_pkg::GAIN_UNITY; ph1 = acge_pkg::PH_OPEN;
                end
                else g1 = g_add[16:0];
            end
            default: ;
        endcase
        ph2 = ph1; h2 = h1;
        if (job.fired)
        begin
            if (ph1 == acge_pkg::PH_OPEN || ph1 == acge_pkg::PH_RELEASE)
                ph2 = acge_pkg::PH_ATTACK;
            if (ph1 == acge_pkg::PH_HOLD) h2 = '0;
        end
        else if (ph1 == acge_pkg::PH_COMPRESS)
        begin
            h2 = '0; ph2 = acge_pkg::PH_HOLD;
        end
    end

    assign job_ready = (state_reg == B_IDLE);
    assign q = 28'((p2_reg + (57'd1 << 28)) >> 29);

    always_comb
    begin
        if (!act_reg)
            sat = pass_reg;
        else if (neg_reg)
            sat = (q > 28'd8388608) ? 24'sh800000 : 24'(-q);
        else
            sat = (q > 28'd8388607) ? 24'sh7FFFFF : 24'(q);
    end

    assign empty    = !out_full_reg;
    assign out_item = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= B_IDLE;
            out_full_reg <= 1'b0;
            for (int i = 0; i < acge_pkg::CHANNELS; i++)
            begin
                phase_reg[i] <= acge_pkg::PH_OPEN;
                gain_reg[i]  <= acge_pkg::GAIN_UNITY;
                hold_reg[i]  <= '0;
            end
        end
        else
        begin
            // A finished result refills the output register in the same
            // cycle that the waiting one is popped.
            if (state_reg == B_DONE && (!out_full_reg || pop))
                out_full_reg <= 1'b1;
            else if (pop && out_full_reg)
                out_full_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                    if (job_valid)
                    begin
                        state_reg <= B_MUL1;
                        if (job.active)
                        begin
                            phase_reg[job.channel] <= ph2;
                            gain_reg[job.channel]  <= g1;
                            hold_reg[job.channel]  <= h2;
                        end
                    end
                B_MUL1: state_reg <= B_MUL2;
                B_MUL2: state_reg <= B_DONE;
                B_DONE:
                    if (!out_full_reg || pop)
                        state_reg <= B_IDLE;
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE)
        begin
            mag_reg      <= job.sample[23] ? 24'(-job.sample) : 24'(job.sample);
            neg_reg      <= job.sample[23];
            act_reg      <= job.active;
            pass_reg     <= job.sample;
            gain_use_reg <= job.active ? g1 : acge_pkg::GAIN_UNITY;
            ph_out_reg   <= job.active ? 3'(ph2) : 3'(ph0);
        end
        if (state_reg == B_MUL1)
            p1_reg <= mag_reg * gain_use_reg;
        if (state_reg == B_MUL2)
            p2_reg <= p1_reg * cfg.makeup_gain;
        if (state_reg == B_DONE && (!out_full_reg || pop))
        begin
            out_reg.sample_out <= sat;
            out_reg.gain_now   <= gain_use_reg;
            out_reg.phase_now  <= ph_out_reg;
        end
    end

endmodule
`default_nettype wire

### src/audio_compressor_gain_envelope_core.sv
`default_nettype none
// Per-channel audio compressor with attack, hold and release envelope.
// Input transactions carry a channel and a signed Q1.23 sample; a
// transaction is taken when push is high and full is low. Results wait in
// an output register: while empty is low the oldest result is on out_item,
// and pop with empty low takes it.
// Configuration is written through cfg_we, cfg_index and cfg_data, one
// register per cycle; the user must do so only while the block holds no
// transaction in flight, as the block itself does not enforce it. The
// front part takes the sample; in RMS mode it writes the sample into the
// channel's window memory and sums the squares, one window entry per
// cycle, so an item holds the front through its read, sum, compare and
// send states after it is taken. In peak mode or when disabled the front
// goes straight to its send state, where it waits for room in the queue.
// A two-entry queue feeds the back part, which updates the envelope and
// scales the sample in two multiplier stages, one item at a time. In RMS
// mode sustained throughput is set by the window summing loop, and
// otherwise by the back. After reset the front clears all 256 window
// entries, one per cycle, and holds full high while it does so. If the
// receiver stalls, one result waits, one more finishes in the back, and
// the queue fills; then full rises and stays high until pop frees room.
module audio_compressor_gain_envelope_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire acge_pkg::in_item_t   in_item,
    output logic                      empty,
    input  wire logic                 pop,
    output acge_pkg::out_item_t       out_item,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [22:0]          cfg_data
);

    acge_pkg::cfg_t cfg_reg;
    acge_pkg::job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.detect_mode  <= 1'b1;
            cfg_reg.threshold    <= 23'd5033165;
            cfg_reg.gain_floor   <= 17'd32768;
            cfg_reg.attack_step  <= 16'd68;
            cfg_reg.release_step <= 16'd68;
            cfg_reg.hold_samples <= 16'd350;
            cfg_reg.makeup_gain  <= 16'd8192;
        end
        else if (cfg_we)
        begin
            unique case (acge_pkg::reg_index_t'(cfg_index))
                acge_pkg::REG_ENABLE:       cfg_reg.enable       <= cfg_data[0];
                acge_pkg::REG_DETECT_MODE:  cfg_reg.detect_mode  <= cfg_data[0];
                acge_pkg::REG_THRESHOLD:    cfg_reg.threshold    <= cfg_data;
                acge_pkg::REG_GAIN_FLOOR:   cfg_reg.gain_floor   <= cfg_data[16:0];
                acge_pkg::REG_ATTACK_STEP:  cfg_reg.attack_step  <= cfg_data[15:0];
                acge_pkg::REG_RELEASE_STEP: cfg_reg.release_step <= cfg_data[15:0];
                acge_pkg::REG_HOLD_SAMPLES: cfg_reg.hold_samples <= cfg_data[15:0];
                acge_pkg::REG_MAKEUP_GAIN:  cfg_reg.makeup_gain  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    acge_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .push(push), .full(full), .in_item(in_item),
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    acge_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
    );

    acge_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
        .empty(empty), .pop(pop), .out_item(out_item)
    );

endmodule
`default_nettype wire
